// ----- sv/sdd_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// sdd_pkg: shared definitions of the stencil derivative deglitch unit
// Sample and result widths, delay line depth, item types and register codes.
// ============================================================================
package sdd_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int MAX_RUN      = 4;
    localparam int DEPTH        = MAX_RUN - 1;
    localparam int PCNT_BITS    = $clog2(DEPTH + 1);
    localparam int OUT_BITS     = 23;
    localparam int RUN_BITS     = 8;
    localparam int MIN_RUN_BITS = 3;
    localparam int CFG_BITS     = 3;
    localparam int CALC_BITS    = (SAMPLE_BITS + 8 > OUT_BITS + 1) ? SAMPLE_BITS + 8
                                                                   : OUT_BITS + 1;

    localparam logic signed [OUT_BITS-1:0] OUT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
    localparam logic signed [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};
    localparam logic [RUN_BITS-1:0]        RUN_SAT = {RUN_BITS{1'b1}};

    typedef enum logic {
        CFG_DERIV_MODE = 1'b0,
        CFG_MIN_RUN    = 1'b1
    } cfg_index_t;

    typedef enum logic {
        ST_RUN   = 1'b0,
        ST_FLUSH = 1'b1
    } sdd_state_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   last_sample;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] deriv_value;
        logic                       last_value;
    } out_item_t;

    typedef logic signed [OUT_BITS-1:0] value_t;

endpackage

// ----- sv/sdd_stencil.sv -----
`timescale 1ns / 1ps
// ============================================================================
// sdd_stencil: five-point derivative numerator
// Forms twelve times the first or second derivative of the centre sample
// from four window samples and the newest sample, saturated to the result
// width.
// ============================================================================
module sdd_stencil
    import sdd_pkg::*;
(
    input  logic [SAMPLE_BITS-1:0] win0,
    input  logic [SAMPLE_BITS-1:0] win1,
    input  logic [SAMPLE_BITS-1:0] win2,
    input  logic [SAMPLE_BITS-1:0] win3,
    input  logic [SAMPLE_BITS-1:0] newest,
    input  logic                   second_order,
    output value_t                 deriv
);

    localparam int PAD = CALC_BITS - SAMPLE_BITS;

    logic signed [CALC_BITS-1:0] y0, y1, y2, y3, yn;
    logic signed [CALC_BITS-1:0] sum;

    assign y0 = $signed({{PAD{1'b0}}, win0});
    assign y1 = $signed({{PAD{1'b0}}, win1});
    assign y2 = $signed({{PAD{1'b0}}, win2});
    assign y3 = $signed({{PAD{1'b0}}, win3});
    assign yn = $signed({{PAD{1'b0}}, newest});

    always_comb begin
        if (second_order) begin
            sum = (y3 <<< 4) + (y1 <<< 4) - (y2 <<< 5) + (y2 <<< 1) - yn - y0;
        end else begin
            sum = (y3 <<< 3) - (y1 <<< 3) + y0 - yn;
        end
    end

    always_comb begin
        if (sum > CALC_BITS'(OUT_MAX)) begin
            deriv = OUT_MAX;
        end else if (sum < CALC_BITS'(OUT_MIN)) begin
            deriv = OUT_MIN;
        end else begin
            deriv = sum[OUT_BITS-1:0];
        end
    end

endmodule

// ----- sv/stencil_derivative_sign_deglitch_unit.sv -----
`timescale 1ns / 1ps
// ============================================================================
// stencil_derivative_sign_deglitch_unit: derivative with sign-run deglitch
// Five-point derivative of a sample stream, short sign runs flipped back in
// a delay line, flushed at the end of each curve.
// ============================================================================
// The unit takes one sample item per cycle through an input register, unless
// a flush runs or a full delay line waits on a held output. Each item is
// handled in the cycle it leaves that register: the stencil, the run tracker
// and the delay line update are one pass of logic, and a value that leaves the
// delay line goes to the single output register. An item whose last_sample is
// set and that produced a derivative is followed by a flush that sends the
// pending values out one per cycle while the output is free. Results are
// delayed by MAX_RUN-1 items plus the window fill of four samples.
module stencil_derivative_sign_deglitch_unit
    import sdd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic                cfg_index,
    input  logic [CFG_BITS-1:0] cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  in_item_t            s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output out_item_t           m_item
);

    logic                    deriv_mode_reg;
    logic [MIN_RUN_BITS-1:0] min_run_reg;

    logic     in_valid_reg;
    in_item_t in_item_reg;

    logic      m_valid_reg, m_valid_next;
    out_item_t m_item_reg, m_item_next;

    sdd_state_t state_reg, state_next;

    logic [SAMPLE_BITS-1:0] win_reg [4];
    logic [SAMPLE_BITS-1:0] win_next [4];
    logic [2:0]             seen_reg, seen_next;
    value_t                 pend_reg [DEPTH];
    value_t                 pend_next [DEPTH];
    value_t                 pend_flip [DEPTH];
    logic [PCNT_BITS-1:0]   pcnt_reg, pcnt_next;
    logic                   dir_reg, dir_next;
    logic [RUN_BITS-1:0]    run_reg, run_next;
    logic [RUN_BITS-1:0]    prev_reg, prev_next;

    value_t              deriv;
    logic                derive, first, evict, out_free, take;
    logic [RUN_BITS-1:0] eff_min, run_cur, prev_cur;
    logic                dir_cur, turns, flip_en;
    logic [RUN_BITS:0]   run_sum;

    function automatic value_t sat_neg(input value_t v);
        if (v == OUT_MIN) begin
            return OUT_MAX;
        end
        return -v;
    endfunction

    sdd_stencil u_stencil (
        .win0        (win_reg[0]),
        .win1        (win_reg[1]),
        .win2        (win_reg[2]),
        .win3        (win_reg[3]),
        .newest      (in_item_reg.sample),
        .second_order(deriv_mode_reg),
        .deriv       (deriv)
    );

    always_comb begin
        if (min_run_reg == '0) begin
            eff_min = RUN_BITS'(1);
        end else if (RUN_BITS'(min_run_reg) > RUN_BITS'(MAX_RUN)) begin
            eff_min = RUN_BITS'(MAX_RUN);
        end else begin
            eff_min = RUN_BITS'(min_run_reg);
        end
    end

    assign derive   = (seen_reg >= 3'd4);
    assign first    = (seen_reg == 3'd4);
    assign evict    = derive && (pcnt_reg == PCNT_BITS'(DEPTH));
    assign out_free = !m_valid_reg || m_ready;
    assign take     = in_valid_reg && (state_reg == ST_RUN) && (!evict || out_free);
    assign s_ready  = !in_valid_reg || take;
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;

    assign run_cur  = first ? eff_min : run_reg;
    assign prev_cur = first ? '0 : prev_reg;
    assign dir_cur  = first ? 1'b1 : dir_reg;
    assign turns    = (deriv < 0 && dir_cur) || (deriv > 0 && !dir_cur);
    assign flip_en  = turns && (run_cur < eff_min);

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            if (flip_en && (i < int'(pcnt_reg)) && (i + int'(run_cur) >= int'(pcnt_reg))) begin
                pend_flip[i] = sat_neg(pend_reg[i]);
            end else begin
                pend_flip[i] = pend_reg[i];
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        win_next     = win_reg;
        seen_next    = seen_reg;
        pend_next    = pend_reg;
        pcnt_next    = pcnt_reg;
        dir_next     = dir_reg;
        run_next     = run_reg;
        prev_next    = prev_reg;
        m_item_next  = m_item_reg;
        m_valid_next = m_valid_reg && !m_ready;
        run_sum      = '0;

        unique case (state_reg)
            ST_RUN: begin
                if (take) begin
                    if (derive) begin
                        if (!turns) begin
                            run_sum  = {1'b0, run_cur} + 1'b1;
                            run_next = run_sum[RUN_BITS] ? RUN_SAT : run_sum[RUN_BITS-1:0];
                            prev_next = prev_cur;
                            dir_next  = dir_cur;
                        end else if (!flip_en) begin
                            prev_next = run_cur;
                            run_next  = RUN_BITS'(1);
                            dir_next  = !dir_cur;
                        end else begin
                            run_sum   = {1'b0, prev_cur} + {1'b0, run_cur};
                            run_next  = run_sum[RUN_BITS] ? RUN_SAT : run_sum[RUN_BITS-1:0];
                            prev_next = prev_cur;
                            dir_next  = !dir_cur;
                        end
                        if (evict) begin
                            m_valid_next = 1'b1;
                            m_item_next  = '{deriv_value: pend_flip[0], last_value: 1'b0};
                            for (int i = 0; i < DEPTH - 1; i++) begin
                                pend_next[i] = pend_flip[i+1];
                            end
                            pend_next[DEPTH-1] = deriv;
                        end else begin
                            for (int i = 0; i < DEPTH; i++) begin
                                pend_next[i] = (i == int'(pcnt_reg)) ? deriv : pend_flip[i];
                            end
                            pcnt_next = pcnt_reg + 1'b1;
                        end
                        if (first) begin
                            seen_next = 3'd5;
                        end
                    end
                    win_next[0] = win_reg[1];
                    win_next[1] = win_reg[2];
                    win_next[2] = win_reg[3];
                    win_next[3] = in_item_reg.sample;
                    if (seen_reg < 3'd4) begin
                        seen_next = seen_reg + 3'd1;
                    end
                    if (in_item_reg.last_sample) begin
                        for (int i = 0; i < 4; i++) begin
                            win_next[i] = '0;
                        end
                        seen_next = '0;
                        dir_next  = 1'b1;
                        run_next  = eff_min;
                        prev_next = '0;
                        if (derive) begin
                            state_next = ST_FLUSH;
                        end
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_item_next  = '{deriv_value: pend_reg[0],
                                     last_value: (pcnt_reg == PCNT_BITS'(1))};
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        pend_next[i] = pend_reg[i+1];
                    end
                    pend_next[DEPTH-1] = '0;
                    pcnt_next = pcnt_reg - 1'b1;
                    if (pcnt_reg == PCNT_BITS'(1)) begin
                        state_next = ST_RUN;
                    end
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deriv_mode_reg <= 1'b0;
            min_run_reg    <= MIN_RUN_BITS'(4);
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_DERIV_MODE: deriv_mode_reg <= cfg_wr_data[0];
                CFG_MIN_RUN:    min_run_reg    <= cfg_wr_data[MIN_RUN_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_item;
        end
        m_item_reg <= m_item_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_RUN;
            m_valid_reg <= 1'b0;
            seen_reg    <= '0;
            pcnt_reg    <= '0;
            dir_reg     <= 1'b1;
            run_reg     <= RUN_BITS'(MAX_RUN);
            prev_reg    <= '0;
            for (int i = 0; i < 4; i++) begin
                win_reg[i] <= '0;
            end
            for (int i = 0; i < DEPTH; i++) begin
                pend_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            seen_reg    <= seen_next;
            pcnt_reg    <= pcnt_next;
            dir_reg     <= dir_next;
            run_reg     <= run_next;
            prev_reg    <= prev_next;
            win_reg     <= win_next;
            pend_reg    <= pend_next;
        end
    end

    a_pcnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pcnt_reg <= PCNT_BITS'(DEPTH))
        else $error("delay line count exceeds its depth");

    a_flush_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FLUSH) |-> (pcnt_reg != '0))
        else $error("flush running with an empty delay line");

    a_flush_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && in_item_reg.last_sample && derive) |=> (state_reg == ST_FLUSH))
        else $error("last item with derivative did not start a flush");

    a_run_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (seen_reg == 3'd5) |-> (run_reg != '0))
        else $error("run length dropped to zero");

    a_no_take_in_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FLUSH) |-> !take)
        else $error("item taken during flush");

endmodule
